// ----- rtl/kmd_pkg.sv -----
// Shared types and constants of the key matrix debouncer.
`timescale 1ns / 1ps
package kmd_pkg;

   localparam int unsigned HIST_W     = 8;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned LINE_W     = 4;
   localparam int unsigned SLOT_CALC_W = 8;

   localparam logic [HIST_W-1:0] HIST_FULL  = 8'hff;
   localparam logic [HIST_W-1:0] HIST_EMPTY = 8'h00;
   localparam logic [HIST_W-1:0] HIST_NEW   = 8'h01;

   // Result queue: deep enough to cover the item in the update stage.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCOUNT_W    = 3;

   typedef struct packed {
      logic [LINE_W-1:0]  row_index;
      logic [LINE_W-1:0]  col_index;
      logic               sense_level;
      logic [STAMP_W-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [LINE_W-1:0]  event_row;
      logic [LINE_W-1:0]  event_col;
      logic               event_pressed;
      logic [STAMP_W-1:0] event_time;
   } rsp_word_type;

   typedef struct packed {
      logic               pressed;
      logic [STAMP_W-1:0] stamp;
      logic [HIST_W-1:0]  history;
   } key_entry_type;

endpackage

// ----- rtl/kmd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module kmd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/kmd_out_queue.sv -----
// Small result queue that decouples the update stage from the result channel.
`timescale 1ns / 1ps
module kmd_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  kmd_pkg::rsp_word_type   push_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output kmd_pkg::rsp_word_type   rsp_word,
   output logic [kmd_pkg::QCOUNT_W-1:0] count
);
   import kmd_pkg::*;

   rsp_word_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                pop;

   assign pop = (count_ff != '0) && !rsp_stall;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_word;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = slot_ff[head_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/key_matrix_debouncer.sv -----
// Top level of the key matrix debouncer: per-key history RAM and update stage.
`timescale 1ns / 1ps
// A result word is offered once its sample word has passed the update stage
// registers and then the result queue. Throughput: one sample word per cycle
// while req_stall is low; each sample makes one read-modify-write of its key
// entry in the state RAM (read in the accept cycle, write in the next).
// Reset clears the per-key valid bits at once, so every key reads as released
// with an empty history and zero stamp; no clearing pass is needed.
module key_matrix_debouncer #(
   parameter int unsigned ROWS = 8,
   parameter int unsigned COLS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kmd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kmd_pkg::rsp_word_type rsp_word
);
   import kmd_pkg::*;

   localparam int unsigned KEYS   = ROWS * COLS;
   localparam int unsigned SLOT_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int unsigned ENTRY_W = $bits(key_entry_type);

   // ---------------------------------------------------------------
   // Accept stage: work out the key slot and launch the RAM read.
   // ---------------------------------------------------------------
   logic                   req_take;
   logic                   s0_in_range;
   logic [SLOT_CALC_W-1:0] s0_slot_wide;
   logic [SLOT_W-1:0]      s0_slot;

   assign req_take = req_valid && !req_stall;

   always_comb begin
      s0_in_range  = ({1'b0, req_word.row_index} < (LINE_W + 1)'(ROWS)) &&
                     ({1'b0, req_word.col_index} < (LINE_W + 1)'(COLS));
      s0_slot_wide = SLOT_CALC_W'(req_word.row_index) * SLOT_CALC_W'(COLS) +
                     SLOT_CALC_W'(req_word.col_index);
      s0_slot      = s0_slot_wide[SLOT_W-1:0];
   end

   // ---------------------------------------------------------------
   // Update stage registers. The valid flag is control; the rest is payload.
   // ---------------------------------------------------------------
   logic               s1_valid_ff;
   logic               s1_in_range_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;
   req_word_type       s1_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_in_range_ff <= s0_in_range;
         s1_slot_ff     <= s0_slot;
         s1_word_ff     <= req_word;
      end
   end

   // ---------------------------------------------------------------
   // State RAM: history, debounced flag and press stamp per key.
   // ---------------------------------------------------------------
   logic               ram_wr_en;
   key_entry_type      ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   kmd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_take),
      .rd_addr (s0_slot),
      .rd_data (ram_rd_data)
   );

   // One valid bit per key: an entry never written reads as the reset entry.
   logic [KEYS-1:0] key_valid_ff, key_valid_in;

   always_comb begin
      key_valid_in = key_valid_ff;
      if (ram_wr_en) begin
         key_valid_in[s1_slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
      end else begin
         key_valid_ff <= key_valid_in;
      end
   end

   // Forwarding: the read of this item was issued in the same cycle as the
   // previous write, so the RAM data is stale when both hit the same key.
   logic               fwd_valid_ff;
   logic [SLOT_W-1:0]  fwd_slot_ff;
   key_entry_type      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= ram_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         fwd_slot_ff <= s1_slot_ff;
         fwd_data_ff <= ram_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Update: shift in the new active level and detect the edges.
   // ---------------------------------------------------------------
   key_entry_type     cur_entry;
   logic [HIST_W-1:0] new_hist;
   logic              press_hit;
   logic              release_hit;
   rsp_word_type      event_word;
   logic              event_push;

   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) begin
         cur_entry = fwd_data_ff;
      end else if (key_valid_ff[s1_slot_ff]) begin
         cur_entry = key_entry_type'(ram_rd_data);
      end else begin
         cur_entry = '0;
      end

      // Active low sense: a low level shifts in a one.
      new_hist = {cur_entry.history[HIST_W-2:0], 1'b0} |
                 (s1_word_ff.sense_level ? HIST_EMPTY : HIST_NEW);

      press_hit   = (new_hist == HIST_FULL)  && !cur_entry.pressed;
      release_hit = (new_hist == HIST_EMPTY) &&  cur_entry.pressed;

      ram_wr_en           = s1_valid_ff && s1_in_range_ff;
      ram_wr_data.history = new_hist;
      ram_wr_data.pressed = press_hit ? 1'b1 : (release_hit ? 1'b0 : cur_entry.pressed);
      ram_wr_data.stamp   = press_hit ? s1_word_ff.now_ms : cur_entry.stamp;

      // Keys outside the matrix are dropped without an event.
      event_push               = ram_wr_en && (press_hit || release_hit);
      event_word.event_row     = s1_word_ff.row_index;
      event_word.event_col     = s1_word_ff.col_index;
      event_word.event_pressed = press_hit;
      event_word.event_time    = press_hit ? s1_word_ff.now_ms : cur_entry.stamp;
   end

   // ---------------------------------------------------------------
   // Result queue: hold events while the consumer stalls. Stall the
   // sample side when the queue could not take both the item in flight and a new one.
   // ---------------------------------------------------------------
   logic [QCOUNT_W-1:0] queue_count;
   logic [QCOUNT_W:0]   queue_claim;

   kmd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (event_push),
      .push_word (event_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .count     (queue_count)
   );

   assign queue_claim = (QCOUNT_W + 1)'(queue_count) + (QCOUNT_W + 1)'(s1_valid_ff);
   assign req_stall   = (queue_claim >= (QCOUNT_W + 1)'(QUEUE_DEPTH));

endmodule

// ----- rtl/kmd_checker.sv -----
// Port-level checks of the key matrix debouncer and their binding.
`timescale 1ns / 1ps
module kmd_checker #(
   parameter int unsigned ROWS = 8,
   parameter int unsigned COLS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input kmd_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input kmd_pkg::rsp_word_type rsp_word
);
   import kmd_pkg::*;

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

   // Events only name keys inside the matrix.
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_word.event_row} < (LINE_W + 1)'(ROWS)) &&
                     ({1'b0, rsp_word.event_col} < (LINE_W + 1)'(COLS))))
      else $error("event for a key outside the matrix");

   // A result appearing from an empty queue follows a sample that has passed the update stage and the queue.
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result word without a sample word");

   // A stalled sample word holds until it is taken.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_word)))
      else $error("stalled sample word changed");

endmodule

bind key_matrix_debouncer kmd_checker #(
   .ROWS (ROWS),
   .COLS (COLS)
) u_kmd_checker (.*);

// ----- test/kmd_event_checker.sv -----
// Watches both channels of the key matrix debouncer, predicts key events and checks them.
`timescale 1ns / 1ps
module kmd_event_checker #(
   parameter int unsigned ROWS = 8,
   parameter int unsigned COLS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  kmd_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  kmd_pkg::rsp_word_type rsp_word,
   output int                    mismatch_count,
   output int                    events_pending
);
   import kmd_pkg::*;

   localparam int unsigned KEYS = ROWS * COLS;

   logic [HIST_W-1:0]  key_history [KEYS];
   logic               key_down    [KEYS];
   logic [STAMP_W-1:0] key_stamp   [KEYS];
   rsp_word_type       expected_events [$];
   int                 fail_total = 0;
   int                 pending_total = 0;

   assign mismatch_count = fail_total;
   assign events_pending = pending_total;

   // One line per mismatch, and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_total++;
   endtask

   task automatic predict_key_event(input req_word_type w);
      int unsigned       slot;
      logic [HIST_W-1:0] hist;
      rsp_word_type      ev;
      if (w.row_index >= ROWS || w.col_index >= COLS)
         return;
      slot = w.row_index * COLS + w.col_index;
      // closed switch (level low) shifts in a one
      hist = {key_history[slot][HIST_W-2:0], ~w.sense_level};
      key_history[slot] = hist;
      ev.event_row = w.row_index;
      ev.event_col = w.col_index;
      if (hist == HIST_FULL && !key_down[slot]) begin
         key_down[slot]   = 1'b1;
         key_stamp[slot]  = w.now_ms;
         ev.event_pressed = 1'b1;
         ev.event_time    = w.now_ms;
         expected_events  = {expected_events, ev};
      end else if (hist == HIST_EMPTY && key_down[slot]) begin
         key_down[slot]   = 1'b0;
         ev.event_pressed = 1'b0;
         ev.event_time    = key_stamp[slot];
         expected_events  = {expected_events, ev};
      end
   endtask

   task automatic check_key_event(input rsp_word_type got);
      rsp_word_type want;
      if (expected_events.size() == 0) begin
         report_mismatch("event word with none pending", got.event_time, '0);
         return;
      end
      want = expected_events.pop_front();
      if (got.event_row !== want.event_row)
         report_mismatch("event_row", 32'(got.event_row), 32'(want.event_row));
      if (got.event_col !== want.event_col)
         report_mismatch("event_col", 32'(got.event_col), 32'(want.event_col));
      if (got.event_pressed !== want.event_pressed)
         report_mismatch("event_pressed", 32'(got.event_pressed),
                         32'(want.event_pressed));
      if (got.event_time !== want.event_time)
         report_mismatch("event_time", got.event_time, want.event_time);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            key_history[k] = HIST_EMPTY;
            key_down[k]    = 1'b0;
            key_stamp[k]   = '0;
         end
         expected_events.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_key_event(req_word);
         if (rsp_valid && !rsp_stall)
            check_key_event(rsp_word);
      end
      pending_total <= expected_events.size();
   end

endmodule

// ----- test/key_matrix_debouncer_tb.sv -----
// Testbench top of the key matrix debouncer: sample stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module key_matrix_debouncer_tb;
   import kmd_pkg::*;

   localparam int unsigned ROWS           = 8;
   localparam int unsigned COLS           = 8;
   localparam int unsigned RANDOM_SAMPLES = 1750;
   localparam int unsigned IDLE_LIMIT     = 2000;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam logic        SENSE_CLOSED   = 1'b0;
   localparam logic        SENSE_OPEN     = 1'b1;
   localparam logic [3:0]  LINE_MAX       = 4'hf;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_word_type req_word  = '0;
   logic         rsp_stall = 1'b0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   int           mismatch_count;
   int           events_pending;

   // Stimulus bookkeeping: millisecond time base, burst length left, and
   // which keys the stimulus currently means to hold down.
   logic [STAMP_W-1:0] ms_now     = '0;
   int                 burst_left = 0;
   bit                 key_held [ROWS*COLS];
   logic [15:0]        stall_tick = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   key_matrix_debouncer #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   kmd_event_checker #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) event_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .events_pending (events_pending)
   );

   // Receiver stall: cycle through four moods in turn -- free
   // running, light random stall, heavy random stall, and a fixed beat.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[9:8])
         2'd0: begin
            rsp_stall <= 1'b0;
         end
         2'd1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2'd2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (stall_tick[2:0] >= 3'd5);
         end
      endcase
   end

   // Advance the millisecond clock a little; now and then jump anywhere so
   // that every bit of the time field toggles, wrap included.
   function automatic logic [STAMP_W-1:0] next_stamp();
      if ($urandom_range(0, 31) == 0)
         ms_now = $urandom;
      else
         ms_now = ms_now + $urandom_range(0, 4);
      return ms_now;
   endfunction

   // Offer one sample word and hold it until taken. Between bursts, drop
   // valid for a random gap; a zero gap keeps valid high across bursts.
   task automatic send_sample(input logic [3:0] row, input logic [3:0] col,
                              input logic level, input logic [STAMP_W-1:0] stamp);
      req_word_type w;
      int           gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // mostly short bursts, now and then a long stretch with no idling
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      w.row_index   = row;
      w.col_index   = col;
      w.sense_level = level;
      w.now_ms      = stamp;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Sample one key a number of times at one level; with bounce set, flip
   // the odd sample to the other level.
   task automatic play_run(input logic [3:0] row, input logic [3:0] col,
                           input logic level, input int run, input bit bounce);
      logic lvl;
      for (int i = 0; i < run; i++) begin
         lvl = (bounce && $urandom_range(0, 9) == 0) ? ~level : level;
         send_sample(row, col, lvl, next_stamp());
      end
   endtask

   initial begin : stimulus
      int          in_range;
      int          pick;
      int          run;
      int unsigned slot;
      logic [3:0]  row;
      logic [3:0]  col;
      logic        target;
      in_range = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Press the far corner key; the debouncing sample carries the top time.
      for (int i = 0; i < 7; i++)
         send_sample(4'(ROWS - 1), 4'(COLS - 1), SENSE_CLOSED, 32'(i));
      send_sample(4'(ROWS - 1), 4'(COLS - 1), SENSE_CLOSED, 32'hffff_ffff);
      // Keys off the matrix must be ignored, even when closed.
      send_sample(LINE_MAX, LINE_MAX, SENSE_CLOSED, 32'h0);
      send_sample(4'(ROWS), 4'h0, SENSE_CLOSED, 32'h5555_aaaa);
      send_sample(4'h0, 4'(COLS), SENSE_CLOSED, 32'haaaa_5555);
      // Release it at time zero; the event must still carry the press time.
      for (int i = 0; i < 8; i++)
         send_sample(4'(ROWS - 1), 4'(COLS - 1), SENSE_OPEN, 32'h0);
      // A short closed run on the first key: history partly fills, no event yet.
      for (int i = 0; i < 5; i++)
         send_sample(4'h0, 4'h0, SENSE_CLOSED, 32'h0);

      // Random part: mostly clean press and release runs on random keys,
      // with some bounce in front; the rest is broken runs and grid noise.
      while (in_range < RANDOM_SAMPLES) begin
         pick = $urandom_range(0, 99);
         row  = 4'($urandom_range(0, ROWS - 1));
         col  = 4'($urandom_range(0, COLS - 1));
         if (pick < 8) begin
            row = 4'($urandom_range(0, LINE_MAX));
            col = 4'($urandom_range(0, LINE_MAX));
            send_sample(row, col, 1'($urandom_range(0, 1)), next_stamp());
            if (row < ROWS && col < COLS)
               in_range++;
         end else if (pick < 18) begin
            run = $urandom_range(1, 7);
            play_run(row, col, 1'($urandom_range(0, 1)), run, 1'b1);
            in_range += run;
         end else begin
            slot   = row * COLS + col;
            target = key_held[slot] ? SENSE_OPEN : SENSE_CLOSED;
            if ($urandom_range(0, 3) == 0) begin
               run = $urandom_range(1, 3);
               play_run(row, col, ~target, run, 1'b1);
               in_range += run;
            end
            run = $urandom_range(8, 11);
            play_run(row, col, target, run, 1'b0);
            in_range += run;
            key_held[slot] = !key_held[slot];
         end
      end

      // Drain: drop valid, let the checker's count settle and the result
      // queue empty, then wait out the pipeline before the verdict.
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_pending != 0 || rsp_valid) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && events_pending == 0)
         $display("key_matrix_debouncer test passed");
      else
         $display("key_matrix_debouncer test failed");
      $finish;
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("key_matrix_debouncer test failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kmd_pkg.sv
rtl/kmd_ram.sv
rtl/kmd_out_queue.sv
rtl/key_matrix_debouncer.sv
rtl/kmd_checker.sv
test/kmd_event_checker.sv
test/key_matrix_debouncer_tb.sv
